FILE: rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types, codes and defaults of the chained hash map set block.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int KEY_W          = 32;
   localparam int CNT_OUT_W      = 11;
   localparam int STATUS_W       = 3;
   localparam int SLOT_CFG_W     = 9;
   localparam int CSR_IDX_W      = 1;
   localparam int DEF_MAX_SLOTS  = 256;
   localparam int DEF_POOL       = 1024;

   // remainder unit: quotient bits retired per cycle and cycle count
   localparam int DIV_BITS       = 4;
   localparam int DIV_STEPS      = KEY_W / DIV_BITS;

   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_TABLE_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_COUNT   = 1'b1;

   localparam logic                  RST_TABLE_ENABLE = 1'b0;
   localparam logic [SLOT_CFG_W-1:0] RST_SLOT_COUNT   = 9'd256;

   // entry memory read address select
   localparam logic [1:0] RD_HEAD = 2'd0;
   localparam logic [1:0] RD_NEXT = 2'd1;
   localparam logic [1:0] RD_FREE = 2'd2;

   typedef struct packed {
      logic                clr_wr;
      logic                req_load;
      logic                bkt_rd;
      logic                walk_init;
      logic                ent_rd;
      logic [1:0]          rd_sel;
      logic                walk_step;
      logic                upd_wr;
      logic                rm_wr;
      logic                unlink_wr;
      logic                pop_free;
      logic                take_new;
      logic                ins_wr;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_code;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic enable;
      logic head_nil;
      logic key_hit;
      logic val_neg1;
      logic next_nil;
      logic steps_last;
      logic free_nil;
      logic pool_full;
      logic rsp_free;
   } sts_type;

endpackage

FILE: rtl/chm_mod.sv
// ----------------------------------------------------------------------------
// chm_mod
// Iterative remainder unit: unsigned 32-bit dividend modulo the slot count,
// DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module chm_mod #(
   parameter int MAX_SLOTS = chm_pkg::DEF_MAX_SLOTS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic [chm_pkg::KEY_W-1:0]              dividend,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]         divisor,
   output logic                                   done,
   output logic [(MAX_SLOTS>1 ? $clog2(MAX_SLOTS) : 1)-1:0] rem
);
   import chm_pkg::*;

   localparam int NW  = $clog2(MAX_SLOTS + 1);
   localparam int SW  = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
   localparam int CW  = DIV_STEPS > 1 ? $clog2(DIV_STEPS) : 1;

   logic [KEY_W-1:0] num_ff, num_in;
   logic [NW-1:0]    div_ff;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;

   always_comb begin
      logic [NW:0]   t;
      logic [NW-1:0] r;
      r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {r, num_ff[KEY_W-1-i]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         r = t[NW-1:0];
      end
      rem_in = r;
      num_in = num_ff << DIV_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff[SW-1:0];

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

endmodule

FILE: rtl/chm_dp.sv
// ----------------------------------------------------------------------------
// chm_dp
// Datapath: bucket and entry memories, walk registers, free list, counters
// and the response register.
// ----------------------------------------------------------------------------
module chm_dp #(
   parameter int MAX_SLOTS    = chm_pkg::DEF_MAX_SLOTS,
   parameter int POOL_ENTRIES = chm_pkg::DEF_POOL
) (
   input  logic                               clock,
   input  logic                               reset,
   input  chm_pkg::cmd_type                   cmd,
   output chm_pkg::sts_type                   sts,
   input  logic signed [chm_pkg::KEY_W-1:0]   req_key,
   input  logic signed [chm_pkg::KEY_W-1:0]   req_mapped_value,
   input  logic                               cfg_enable,
   input  logic [chm_pkg::SLOT_CFG_W-1:0]     cfg_slots,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [chm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [chm_pkg::CNT_OUT_W-1:0]      rsp_total_entries,
   output logic [chm_pkg::CNT_OUT_W-1:0]      rsp_bucket_entries
);
   import chm_pkg::*;

   localparam int NW = $clog2(MAX_SLOTS + 1);
   localparam int SW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
   localparam int PW = $clog2(POOL_ENTRIES + 1);  // pointer / count, holds nil
   localparam int IW = $clog2(POOL_ENTRIES);
   localparam int OW = PW > CNT_OUT_W ? PW : CNT_OUT_W;
   localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

   // request word
   logic [KEY_W-1:0] key_ff, val_ff;
   logic [KEY_W-1:0] mag;
   logic [NW-1:0]    slots_eff;
   logic             div_done;
   logic [SW-1:0]    div_rem;

   always_comb begin
      mag = req_key[KEY_W-1] ? (KEY_W'(0) - KEY_W'(req_key)) : KEY_W'(req_key);
      if (cfg_slots == '0) begin
         slots_eff = NW'(1);
      end else if (32'(cfg_slots) > 32'(MAX_SLOTS)) begin
         slots_eff = NW'(MAX_SLOTS);
      end else begin
         slots_eff = NW'(cfg_slots);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         key_ff <= KEY_W'(req_key);
         val_ff <= KEY_W'(req_mapped_value);
      end
   end

   chm_mod #(.MAX_SLOTS(MAX_SLOTS)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.req_load),
      .dividend (mag),
      .divisor  (slots_eff),
      .done     (div_done),
      .rem      (div_rem)
   );

   // bucket memory
   logic [PW-1:0] head_mem [MAX_SLOTS];
   logic [PW-1:0] cnt_mem  [MAX_SLOTS];
   logic [PW-1:0] bq_head, bq_cnt;
   logic [SW-1:0] bidx_ff, clr_idx_ff;
   logic          bkt_we;
   logic [SW-1:0] bkt_wa;
   logic [PW-1:0] bkt_wh, bkt_wc;

   // walk and allocation state
   logic [PW-1:0] head_ff, cnt_ff, cur_ff, prev_ff, nx_ff, steps_ff;
   logic [PW-1:0] free_ff, mark_ff, live_ff, fresh_ff;
   logic [PW-1:0] cnt_dec;

   // entry memory
   logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
   logic [KEY_W-1:0] val_mem  [POOL_ENTRIES];
   logic [PW-1:0]    next_mem [POOL_ENTRIES];
   logic [KEY_W-1:0] eq_key;
   logic [PW-1:0]    eq_next;
   logic [PW-1:0]    ent_ra;
   logic             kv_we, nx_we;
   logic [PW-1:0]    kv_wa, nx_wa, nx_wd;
   logic [KEY_W-1:0] kw_key, kw_val;

   assign cnt_dec = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;

   always_comb begin
      bkt_we = cmd.clr_wr | cmd.unlink_wr | cmd.ins_wr;
      bkt_wa = cmd.clr_wr ? clr_idx_ff : bidx_ff;
      bkt_wh = NIL;
      bkt_wc = '0;
      if (cmd.unlink_wr) begin
         bkt_wh = (prev_ff == NIL) ? nx_ff : head_ff;
         bkt_wc = cnt_dec;
      end else if (cmd.ins_wr) begin
         bkt_wh = fresh_ff;
         bkt_wc = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         head_mem[bkt_wa] <= bkt_wh;
         cnt_mem[bkt_wa]  <= bkt_wc;
      end
      if (cmd.bkt_rd) begin
         bq_head <= head_mem[div_rem];
         bq_cnt  <= cnt_mem[div_rem];
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: ent_ra = bq_head;
         RD_NEXT: ent_ra = eq_next;
         RD_FREE: ent_ra = free_ff;
         default: ent_ra = bq_head;
      endcase
   end

   always_comb begin
      kv_we  = cmd.rm_wr | cmd.upd_wr | cmd.ins_wr;
      kv_wa  = cmd.ins_wr ? fresh_ff : cur_ff;
      kw_key = cmd.rm_wr ? '1 : key_ff;
      kw_val = cmd.rm_wr ? '1 : val_ff;
      nx_we  = cmd.rm_wr | cmd.ins_wr | (cmd.unlink_wr && prev_ff != NIL);
      nx_wa  = cur_ff;
      nx_wd  = free_ff;
      if (cmd.ins_wr) begin
         nx_wa = fresh_ff;
         nx_wd = head_ff;
      end else if (cmd.unlink_wr) begin
         nx_wa = prev_ff;
         nx_wd = nx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         key_mem[kv_wa[IW-1:0]] <= kw_key;
         val_mem[kv_wa[IW-1:0]] <= kw_val;
      end
      if (nx_we) begin
         next_mem[nx_wa[IW-1:0]] <= nx_wd;
      end
      if (cmd.ent_rd) begin
         eq_key  <= key_mem[ent_ra[IW-1:0]];
         eq_next <= next_mem[ent_ra[IW-1:0]];
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.bkt_rd) begin
         bidx_ff <= div_rem;
      end
      if (cmd.walk_init) begin
         head_ff  <= bq_head;
         cnt_ff   <= bq_cnt;
         cur_ff   <= bq_head;
         prev_ff  <= NIL;
         steps_ff <= '0;
      end else if (cmd.walk_step) begin
         prev_ff  <= cur_ff;
         cur_ff   <= eq_next;
         steps_ff <= steps_ff + 1'b1;
      end else if (cmd.unlink_wr) begin
         cnt_ff <= cnt_dec;
      end else if (cmd.ins_wr) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.rm_wr) begin
         nx_ff <= eq_next;
      end
      if (cmd.pop_free) begin
         fresh_ff <= free_ff;
      end else if (cmd.take_new) begin
         fresh_ff <= mark_ff;
      end
   end

   // free list, pool mark, live count, clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff    <= NIL;
         mark_ff    <= '0;
         live_ff    <= '0;
         clr_idx_ff <= '0;
      end else begin
         if (cmd.clr_wr) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (cmd.rm_wr) begin
            free_ff <= cur_ff;
            if (live_ff != '0) begin
               live_ff <= live_ff - 1'b1;
            end
         end else if (cmd.pop_free) begin
            free_ff <= eq_next;
         end
         if (cmd.take_new) begin
            mark_ff <= mark_ff + 1'b1;
         end
         if (cmd.ins_wr) begin
            live_ff <= live_ff + 1'b1;
         end
      end
   end

   // response word
   logic [OW-1:0] live_w, cnt_w;
   assign live_w = OW'(live_ff);
   assign cnt_w  = OW'(cnt_ff);

   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status         <= cmd.rsp_code;
         rsp_total_entries  <= live_w[CNT_OUT_W-1:0];
         rsp_bucket_entries <= cnt_w[CNT_OUT_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sts.clr_last   = (clr_idx_ff == SW'(MAX_SLOTS - 1));
      sts.div_done   = div_done;
      sts.enable     = cfg_enable;
      sts.head_nil   = (bq_head == NIL);
      sts.key_hit    = (eq_key == key_ff);
      sts.val_neg1   = (val_ff == '1);
      sts.next_nil   = (eq_next == NIL);
      sts.steps_last = (steps_ff == PW'(POOL_ENTRIES - 1));
      sts.free_nil   = (free_ff == NIL);
      sts.pool_full  = (mark_ff == PW'(POOL_ENTRIES));
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   a_live_bounded: assert property (@(posedge clock) disable iff (reset)
      live_ff <= PW'(POOL_ENTRIES))
      else $error("live count above pool size");

   a_free_was_used: assert property (@(posedge clock) disable iff (reset)
      (free_ff != NIL) |-> (free_ff < mark_ff))
      else $error("free list points at a never-used entry");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

endmodule

FILE: rtl/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl
// Controller: sequences clearing, remainder, bucket read, chain walk,
// update, unlink or insert, and response hand-off.
// ----------------------------------------------------------------------------
module chm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chm_pkg::sts_type sts,
   output chm_pkg::cmd_type cmd
);
   import chm_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_BKT    = 4'd3;
   localparam logic [3:0] S_ECHK   = 4'd4;
   localparam logic [3:0] S_UNLINK = 4'd5;
   localparam logic [3:0] S_ALLOC  = 4'd6;
   localparam logic [3:0] S_FPOP   = 4'd7;
   localparam logic [3:0] S_INS    = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.bkt_rd = 1'b1;
               state_in   = S_BKT;
            end
         end
         S_BKT: begin
            cmd.walk_init = 1'b1;
            if (!sts.enable) begin
               code_in  = ST_IGNORED;
               state_in = S_DONE;
            end else if (sts.head_nil) begin
               state_in = S_ALLOC;
            end else begin
               cmd.ent_rd = 1'b1;
               cmd.rd_sel = RD_HEAD;
               state_in   = S_ECHK;
            end
         end
         S_ECHK: begin
            if (sts.key_hit) begin
               if (sts.val_neg1) begin
                  cmd.rm_wr = 1'b1;
                  code_in   = ST_REMOVED;
                  state_in  = S_UNLINK;
               end else begin
                  cmd.upd_wr = 1'b1;
                  code_in    = ST_UPDATED;
                  state_in   = S_DONE;
               end
            end else begin
               cmd.walk_step = 1'b1;
               if (sts.next_nil || sts.steps_last) begin
                  state_in = S_ALLOC;
               end else begin
                  cmd.ent_rd = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end
         end
         S_UNLINK: begin
            cmd.unlink_wr = 1'b1;
            state_in      = S_DONE;
         end
         S_ALLOC: begin
            if (!sts.free_nil) begin
               cmd.ent_rd = 1'b1;
               cmd.rd_sel = RD_FREE;
               state_in   = S_FPOP;
            end else if (!sts.pool_full) begin
               cmd.take_new = 1'b1;
               state_in     = S_INS;
            end else begin
               code_in  = ST_FULL;
               state_in = S_DONE;
            end
         end
         S_FPOP: begin
            cmd.pop_free = 1'b1;
            state_in     = S_INS;
         end
         S_INS: begin
            cmd.ins_wr = 1'b1;
            code_in    = ST_INSERTED;
            state_in   = S_DONE;
         end
         S_DONE: begin
            cmd.rsp_code = code_ff;
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_IGNORED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DIV))
      else $error("accepted word did not start the remainder");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && sts.rsp_free) |=> (state_ff == S_IDLE))
      else $error("response hand-off did not return to idle");

endmodule

FILE: rtl/chained_hash_map_set.sv
// ----------------------------------------------------------------------------
// chained_hash_map_set
// Key-to-value map as a chained hash table over a fixed entry pool.
// ----------------------------------------------------------------------------
// One word is in flight at a time. The remainder unit reduces the 32-bit key
// magnitude, 4 quotient bits per cycle; then the bucket is read, the chain
// is walked one entry at a time in the single-port entry memory, the word is
// applied by update, unlink or insert, or dropped (a freed entry is reused by
// popping it from the free list first), and the response word is handed to
// the output register. A finished response may wait in the output register
// while the next word is taken. After reset the bucket memory is cleared,
// one bucket per cycle, all MAX_SLOTS buckets; no word is accepted meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_map_set #(
   parameter int MAX_SLOTS    = chm_pkg::DEF_MAX_SLOTS,
   parameter int POOL_ENTRIES = chm_pkg::DEF_POOL
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [chm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [chm_pkg::SLOT_CFG_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [chm_pkg::KEY_W-1:0]   req_key,
   input  logic signed [chm_pkg::KEY_W-1:0]   req_mapped_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [chm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [chm_pkg::CNT_OUT_W-1:0]      rsp_total_entries,
   output logic [chm_pkg::CNT_OUT_W-1:0]      rsp_bucket_entries
);
   import chm_pkg::*;

   logic                  enable_ff;
   logic [SLOT_CFG_W-1:0] slots_ff;
   cmd_type               cmd;
   sts_type               sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= RST_TABLE_ENABLE;
         slots_ff  <= RST_SLOT_COUNT;
      end else if (csr_we) begin
         case (csr_index)
            REG_TABLE_ENABLE: enable_ff <= csr_wdata[0];
            REG_SLOT_COUNT:   slots_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   chm_dp #(
      .MAX_SLOTS    (MAX_SLOTS),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_key            (req_key),
      .req_mapped_value   (req_mapped_value),
      .cfg_enable         (enable_ff),
      .cfg_slots          (slots_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_total_entries  (rsp_total_entries),
      .rsp_bucket_entries (rsp_bucket_entries)
   );

endmodule
